@@ src/form_urlencoded_stream_decoder_core_defines.svh @@
// assertion macros for the form-urlencoded stream decoder
`ifndef FORM_URLENCODED_STREAM_DECODER_CORE_DEFINES_SVH
`define FORM_URLENCODED_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

@@ src/fusd_pkg.sv @@
// shared types, character codes and hex helpers for the urlencoded decoder
package fusd_pkg;

  localparam int MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    KIND_CONTENT  = 2'd0,
    KIND_KEY_END  = 2'd1,
    KIND_PAIR_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_PCT   = 2'd1,
    PHASE_DIGIT = 2'd2
  } phase_t;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // one queue entry: all results caused by one input byte
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt_m1;
    logic                      last;
  } entry_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + HEX_TEN;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - CH_LA + HEX_TEN;
    end
    return v;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] hv;
    logic [7:0] lv;
    hv = hex_value(hi);
    lv = hex_value(lo);
    return {hv[3:0], 4'h0} + lv;
  endfunction

  // byte outside any escape
  function automatic result_t plain_result(input logic [7:0] c);
    result_t r;
    unique case (c)
      CH_EQ: begin
        r.data = 8'h00;
        r.kind = KIND_KEY_END;
      end
      CH_AMP: begin
        r.data = 8'h00;
        r.kind = KIND_PAIR_END;
      end
      CH_PLUS: begin
        r.data = CH_SPACE;
        r.kind = KIND_CONTENT;
      end
      default: begin
        r.data = c;
        r.kind = KIND_CONTENT;
      end
    endcase
    return r;
  endfunction

endpackage

@@ src/fusd_front.sv @@
// front end: takes body bytes, tracks escapes and builds one queue entry per byte that yields results
module fusd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             end_of_body,
  input  logic             full,
  output logic             push,
  output fusd_pkg::entry_t entry
);

  fusd_pkg::phase_t phase;
  fusd_pkg::phase_t phase_next;
  logic [7:0]       held;
  logic [7:0]       held_next;
  logic             segment_open;
  logic             segment_open_next;
  logic             accept;
  logic [1:0]       cnt;

  assign accept = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fusd_pkg::PHASE_IDLE;
      held         <= 8'h00;
      segment_open <= 1'b0;
    end else begin
      phase        <= phase_next;
      held         <= held_next;
      segment_open <= segment_open_next;
    end
  end

  // next state
  always_comb begin
    fusd_pkg::result_t pr;
    pr                = fusd_pkg::plain_result(in_byte);
    phase_next        = phase;
    held_next         = held;
    segment_open_next = segment_open;
    if (accept) begin
      if (end_of_body) begin
        phase_next        = fusd_pkg::PHASE_IDLE;
        held_next         = 8'h00;
        segment_open_next = 1'b0;
      end else begin
        unique case (phase)
          fusd_pkg::PHASE_PCT: begin
            held_next  = in_byte;
            phase_next = fusd_pkg::PHASE_DIGIT;
          end
          fusd_pkg::PHASE_DIGIT: begin
            phase_next        = fusd_pkg::PHASE_IDLE;
            held_next         = 8'h00;
            segment_open_next = 1'b1;
          end
          default: begin
            phase_next = fusd_pkg::PHASE_IDLE;
            if (in_byte == fusd_pkg::CH_PCT) begin
              phase_next = fusd_pkg::PHASE_PCT;
            end else begin
              segment_open_next = (pr.kind == fusd_pkg::KIND_CONTENT);
            end
          end
        endcase
      end
    end
  end

  // outputs: results caused by this byte
  always_comb begin
    fusd_pkg::result_t pr;
    logic              seg;
    pr    = fusd_pkg::plain_result(in_byte);
    seg   = segment_open;
    cnt   = 2'd0;
    entry = '0;
    unique case (phase)
      fusd_pkg::PHASE_PCT: begin
        if (end_of_body) begin
          // escape cut short: the percent sign goes out as is
          entry.res[cnt] = '{fusd_pkg::CH_PCT, fusd_pkg::KIND_CONTENT};
          cnt            = cnt + 2'd1;
          seg            = 1'b1;
          if (in_byte == fusd_pkg::CH_PCT) begin
            entry.res[cnt] = '{in_byte, fusd_pkg::KIND_CONTENT};
          end else begin
            entry.res[cnt] = pr;
            seg            = (pr.kind == fusd_pkg::KIND_CONTENT);
          end
          cnt = cnt + 2'd1;
        end
      end
      fusd_pkg::PHASE_DIGIT: begin
        entry.res[cnt] = '{fusd_pkg::decode_pair(held, in_byte), fusd_pkg::KIND_CONTENT};
        cnt            = cnt + 2'd1;
        seg            = 1'b1;
      end
      default: begin
        if (in_byte == fusd_pkg::CH_PCT) begin
          if (end_of_body) begin
            entry.res[cnt] = '{in_byte, fusd_pkg::KIND_CONTENT};
            cnt            = cnt + 2'd1;
            seg            = 1'b1;
          end
        end else begin
          entry.res[cnt] = pr;
          cnt            = cnt + 2'd1;
          seg            = (pr.kind == fusd_pkg::KIND_CONTENT);
        end
      end
    endcase
    if (end_of_body && seg) begin
      entry.res[cnt] = '{8'h00, fusd_pkg::KIND_PAIR_END};
      cnt            = cnt + 2'd1;
    end
    entry.cnt_m1 = cnt - 2'd1;
    entry.last   = end_of_body;
    push         = accept && (cnt != 2'd0);
  end

endmodule

@@ src/fusd_queue.sv @@
// short queue of result groups between front and back
module fusd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  fusd_pkg::entry_t             wr_entry,
  input  logic                         pop,
  output fusd_pkg::entry_t             head,
  output logic                         head_valid,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  fusd_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign head       = slots[rd_ptr];
  assign head_valid = (level != '0);
  assign full       = (level == LVL_W'(DEPTH));

endmodule

@@ src/fusd_back.sv @@
// back end: walks the results of each queue entry into the output register
module fusd_back (
  input  logic             clk,
  input  logic             rst,
  input  fusd_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic             last
);

  logic       pos;
  logic [1:0] pos_idx;
  logic [1:0] pos_next;
  logic [1:0] sel;
  logic       take;
  logic       load;
  logic       at_end;

  logic [1:0] cur;
  assign pos_idx = cur;
  assign pos     = (cur != 2'd0);
  assign sel     = pos_idx;

  assign take   = !out_valid || !out_stall;
  assign load   = head_valid && take;
  assign at_end = (sel == head.cnt_m1);
  assign pop    = load && at_end;

  always_comb begin
    pos_next = cur;
    if (load) begin
      pos_next = at_end ? 2'd0 : cur + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      cur <= pos_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.res[sel].data;
      kind     <= head.res[sel].kind;
      last     <= head.last && at_end && (pos || !pos);
    end
  end

endmodule

@@ src/form_urlencoded_stream_decoder_core.sv @@
// top level of the form-urlencoded stream decoder
// Takes one body byte per cycle while in_stall is low and emits content bytes and key-end /
// pair-end markers, with last set on the final result of each body. The front end decodes '+'
// and percent escapes and turns each byte into a group of zero to three results; groups wait
// in a QUEUE_DEPTH-entry queue, and the back end sends one result per cycle through its output
// register while out_stall does not hold it. A byte yields at most one result except the final
// byte of a body, which can yield two or three, so the sustained rate is one byte per cycle when
// nothing stalls, while the extra results of a body's final byte take turns on the single result
// port of the back end. An accepted byte's results pass through a queue slot and then the output register.
`include "form_urlencoded_stream_decoder_core_defines.svh"

module form_urlencoded_stream_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_body,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  fusd_pkg::entry_t   push_entry;
  fusd_pkg::entry_t   head;
  logic               push;
  logic               pop;
  logic               head_valid;
  logic               q_full;
  logic [LVL_W-1:0]   q_level;

  assign in_stall = q_full;

  fusd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .end_of_body (end_of_body),
    .full        (q_full),
    .push        (push),
    .entry       (push_entry)
  );

  fusd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full),
    .level      (q_level)
  );

  fusd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .last       (last)
  );

  `ASSERT_IMPLIES(a_marker_byte_zero, clk, rst, out_valid && kind != fusd_pkg::KIND_CONTENT, out_byte == 8'h00)
  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !q_full)
  `ASSERT_NEVER(a_level_range, clk, rst, q_level > LVL_W'(QUEUE_DEPTH))

endmodule

@@ verif/form_urlencoded_stream_decoder_core_tb.sv @@
// self-checking testbench for the form-urlencoded stream decoder core
module form_urlencoded_stream_decoder_core_tb;
  import fusd_pkg::*;

  localparam int IDLE_PCT        = 27;
  localparam int HOLD_CYCLES     = 60;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 20;
  localparam int RANDOM_REQUESTS = 280;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } decoded_t;

  class decode_scoreboard;
    phase_t     esc_phase  = PHASE_IDLE;
    logic [7:0] held_digit = 8'h00;
    bit         seg_open   = 1'b0;
    decoded_t   decoded_q[$];
    int         errors     = 0;
    int         checked    = 0;

    function void push_result(logic [7:0] data, kind_t k);
      decoded_t d;
      d.data = data;
      d.kind = k;
      d.last = 1'b0;
      decoded_q.push_back(d);
    endfunction

    function int digit_value(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return c - CH_0;
      if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
      if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
      return c;
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == CH_EQ) begin
        push_result(8'h00, KIND_KEY_END);
        seg_open = 1'b0;
      end else if (c == CH_AMP) begin
        push_result(8'h00, KIND_PAIR_END);
        seg_open = 1'b0;
      end else if (c == CH_PLUS) begin
        push_result(CH_SPACE, KIND_CONTENT);
        seg_open = 1'b1;
      end else begin
        push_result(c, KIND_CONTENT);
        seg_open = 1'b1;
      end
    endfunction

    // predict every result caused by one accepted request
    function void note_request(logic [7:0] c, logic eob);
      int       start;
      int       v;
      decoded_t tail;
      start = decoded_q.size();
      case (esc_phase)
        PHASE_PCT: begin
          if (eob) begin
            // escape cut short: '%' goes out literally
            push_result(CH_PCT, KIND_CONTENT);
            seg_open = 1'b1;
            if (c == CH_PCT) push_result(c, KIND_CONTENT);
            else plain_char(c);
          end else begin
            held_digit = c;
            esc_phase  = PHASE_DIGIT;
          end
        end
        PHASE_DIGIT: begin
          v = (digit_value(held_digit) * 16 + digit_value(c)) & 255;
          push_result(8'(v), KIND_CONTENT);
          seg_open   = 1'b1;
          esc_phase  = PHASE_IDLE;
          held_digit = 8'h00;
        end
        default: begin
          esc_phase = PHASE_IDLE;
          if (c == CH_PCT) begin
            if (eob) begin
              push_result(c, KIND_CONTENT);
              seg_open = 1'b1;
            end else begin
              esc_phase = PHASE_PCT;
            end
          end else begin
            plain_char(c);
          end
        end
      endcase
      if (eob) begin
        if (seg_open) push_result(8'h00, KIND_PAIR_END);
        if (decoded_q.size() > start) begin
          tail      = decoded_q.pop_back();
          tail.last = 1'b1;
          decoded_q.push_back(tail);
        end
        esc_phase  = PHASE_IDLE;
        held_digit = 8'h00;
        seg_open   = 1'b0;
      end
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] k, logic lst);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual byte %h kind %0d last %0b",
                 $time, data, k, lst);
        return;
      end
      e = decoded_q.pop_front();
      checked++;
      if (data !== e.data) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, e.data, data);
      end
      if (k !== e.kind) begin
        errors++;
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
      end
      if (lst !== e.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, e.last, lst);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       end_of_body = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  decode_scoreboard sb;
  logic [7:0]       body_q[$];
  bit               idle_en        = 1'b1;
  int               hold_left      = 0;
  int               requests_sent  = 0;
  int               bodies_sent    = 0;
  int               stalled_cycles = 0;

  form_urlencoded_stream_decoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_body(end_of_body),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (idle_en) begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_byte, kind, last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no request moved for %0d cycles", $time,
                 stalled_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eob);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_body <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b, eob);
    requests_sent++;
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_item(body_q[i], i == body_q.size() - 1);
    bodies_sent++;
    body_q.delete();
  endtask

  // stop offering requests until every predicted result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return CH_0 + n;
    return (upper ? CH_UA : CH_LA) + n - 10;
  endfunction

  function automatic void add_escape(logic [7:0] v);
    body_q.push_back(CH_PCT);
    body_q.push_back(hex_char(v[7:4], $urandom_range(0, 1)));
    body_q.push_back(hex_char(v[3:0], $urandom_range(0, 1)));
  endfunction

  function automatic void add_token();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) body_q.push_back(8'h61 + $urandom_range(0, 25));
    else if (r == 6) body_q.push_back(CH_0 + $urandom_range(0, 9));
    else if (r == 7) body_q.push_back(CH_PLUS);
    else add_escape($urandom_range(0, 255));
  endfunction

  // well-formed key=value&key=value with random content
  function automatic void build_form();
    int pairs;
    pairs = $urandom_range(1, 3);
    for (int p = 0; p < pairs; p++) begin
      repeat ($urandom_range(1, 4)) add_token();
      body_q.push_back(CH_EQ);
      repeat ($urandom_range(0, 4)) add_token();
      if (p < pairs - 1 || $urandom_range(0, 3) == 0) body_q.push_back(CH_AMP);
    end
  endfunction

  function automatic void build_noise();
    logic [7:0] specials[6];
    specials = '{CH_PCT, CH_PLUS, CH_EQ, CH_AMP, CH_UF, CH_9};
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 9) < 4) body_q.push_back($urandom_range(0, 255));
      else body_q.push_back(specials[$urandom_range(0, 5)]);
    end
  endfunction

  // escape cut off by the end of the body
  function automatic void build_broken();
    repeat ($urandom_range(0, 3)) add_token();
    body_q.push_back(CH_PCT);
    if ($urandom_range(0, 1)) body_q.push_back($urandom_range(0, 255));
  endfunction

  task automatic random_body();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) build_form();
    else if (r < 9) build_noise();
    else build_broken();
    send_body();
  endtask

  initial begin
    int base;
    sb = new;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed bodies
    add_text("k=%41&");
    send_body();
    add_text("%3d%zf+");
    send_body();
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    body_q.push_back(CH_EQ);
    send_body();
    add_text("%");
    send_body();
    add_text("x%");
    send_body();
    add_text("%4");
    send_body();
    add_text("%%");
    send_body();
    add_text("%&");
    send_body();
    add_text("%9F");
    send_body();

    base = requests_sent;
    while (requests_sent < base + 110) random_body();

    // receiver holds off while the sender keeps offering, no idling on either side
    idle_en   = 1'b0;
    hold_left = HOLD_CYCLES;
    while (requests_sent < base + 180) random_body();
    drain();
    idle_en = 1'b1;

    while (requests_sent < base + RANDOM_REQUESTS) random_body();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.decoded_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results expected, actual none arrived", $time, sb.decoded_q.size());
    end
    $display("run covered %0d bodies and %0d requests, %0d decoded results checked",
             bodies_sent, requests_sent, sb.checked);
    $display("including cut escapes, non-hex escapes, long output hold-off and full-rate bursts");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
